>>> sv/maa_pkg.sv
`timescale 1ns / 1ps

package maa_pkg;

  localparam int DATA_W  = 32;
  localparam int MOD_W   = 31;
  localparam int ACT_W   = 2;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int CNT_W   = $clog2(PROD_W);

  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SUB  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_MUL  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;   // capture the incoming word
    logic calc;      // form the exact 64-bit result
    logic abs_en;    // split the result into sign and magnitude
    logic div_step;  // one restoring remainder step
    logic commit;    // write the final value into the accumulator
  } maa_cmd_t;

  typedef struct packed {
    logic mod_zero;
  } maa_stat_t;

endpackage

>>> sv/maa_ifs.sv
`timescale 1ns / 1ps

interface maa_in_if;
  logic                                valid;
  logic                                ready;
  logic [maa_pkg::ACT_W-1:0]           action;
  logic signed [maa_pkg::DATA_W-1:0]   operand;

  modport source (output valid, action, operand, input ready);
  modport sink   (input valid, action, operand, output ready);
endinterface

interface maa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [maa_pkg::DATA_W-1:0]   result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

interface maa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [maa_pkg::MOD_W-1:0]           modulus;

  modport source (output valid, modulus, input ready);
  modport sink   (input valid, modulus, output ready);
endinterface

>>> sv/maa_ctrl.sv
`timescale 1ns / 1ps

module maa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  maa_pkg::maa_stat_t  stat,
  output maa_pkg::maa_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_ABS  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIX  = 3'd4;

  localparam logic [maa_pkg::CNT_W-1:0] CNT_LAST = maa_pkg::CNT_W'(maa_pkg::PROD_W - 1);

  logic [2:0]                state_r, state_nxt;
  logic [maa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.abs_en = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = stat.mod_zero ? ST_FIX : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        // The accumulator doubles as the output register, so it may only
        // change once the previous word has been taken.
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/maa_dp.sv
`timescale 1ns / 1ps

module maa_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  maa_pkg::maa_cmd_t                  cmd,
  output maa_pkg::maa_stat_t                 stat,
  input  logic [maa_pkg::ACT_W-1:0]          in_action,
  input  logic signed [maa_pkg::DATA_W-1:0]  in_operand,
  input  logic                               cfg_we,
  input  logic [maa_pkg::MOD_W-1:0]          cfg_modulus,
  output logic signed [maa_pkg::DATA_W-1:0]  acc
);

  logic [maa_pkg::MOD_W-1:0]          mod_r;
  logic signed [maa_pkg::DATA_W-1:0]  acc_r, acc_nxt;
  logic [maa_pkg::ACT_W-1:0]          act_r;
  logic signed [maa_pkg::DATA_W-1:0]  op_r;
  logic signed [maa_pkg::PROD_W-1:0]  res_r, res_nxt;
  logic [maa_pkg::PROD_W-1:0]         mag_r;
  logic                               neg_r;
  logic [maa_pkg::MOD_W-1:0]          rem_r, rem_nxt;

  logic signed [maa_pkg::PROD_W-1:0]  prod;
  logic signed [maa_pkg::PROD_W-1:0]  acc_ext, op_ext;
  logic [maa_pkg::MOD_W:0]            trial, trial_sub;
  logic [maa_pkg::MOD_W-1:0]          rem_neg, mod_minus;

  assign stat.mod_zero = (mod_r == '0);
  assign acc           = acc_r;

  assign acc_ext = maa_pkg::PROD_W'(acc_r);
  assign op_ext  = maa_pkg::PROD_W'(op_r);
  assign prod    = acc_r * op_r;

  always_comb begin
    case (act_r)
      maa_pkg::ACT_LOAD: res_nxt = op_ext;
      maa_pkg::ACT_ADD:  res_nxt = acc_ext + op_ext;
      maa_pkg::ACT_SUB:  res_nxt = acc_ext - op_ext;
      maa_pkg::ACT_MUL:  res_nxt = prod;
      default:           res_nxt = op_ext;
    endcase
  end

  // Restoring remainder step: shift in the next magnitude bit, subtract the
  // modulus when it fits. The remainder always stays below the modulus.
  assign trial     = {rem_r, mag_r[maa_pkg::PROD_W-1]};
  assign trial_sub = trial - {1'b0, mod_r};
  assign rem_nxt   = (trial >= {1'b0, mod_r}) ? trial_sub[maa_pkg::MOD_W-1:0]
                                              : trial[maa_pkg::MOD_W-1:0];

  assign rem_neg   = maa_pkg::MOD_W'(0) - rem_r;
  assign mod_minus = mod_r - rem_r;

  always_comb begin
    if (stat.mod_zero) begin
      acc_nxt = res_r[maa_pkg::DATA_W-1:0];
    end else if (act_r == maa_pkg::ACT_LOAD) begin
      // Load keeps the sign of the operand, as a truncating remainder does.
      acc_nxt = neg_r ? {1'b1, rem_neg} : {1'b0, rem_r};
      if (rem_r == '0) begin
        acc_nxt = '0;
      end
    end else if (neg_r && (rem_r != '0)) begin
      acc_nxt = {1'b0, mod_minus};
    end else begin
      acc_nxt = {1'b0, rem_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= '0;
      acc_r <= '0;
    end else begin
      if (cfg_we) begin
        mod_r <= cfg_modulus;
      end
      if (cmd.commit) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      act_r <= in_action;
      op_r  <= in_operand;
    end
    if (cmd.calc) begin
      res_r <= res_nxt;
    end
    if (cmd.abs_en) begin
      neg_r <= res_r[maa_pkg::PROD_W-1];
      mag_r <= res_r[maa_pkg::PROD_W-1] ? maa_pkg::PROD_W'(-res_r) : res_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      mag_r <= {mag_r[maa_pkg::PROD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

endmodule

>>> sv/modular_accumulator_alu.sv
`timescale 1ns / 1ps

// Modular accumulator: each input word (action, operand) loads, adds, subtracts
// or multiplies into a signed 32-bit accumulator, and one result word carrying
// the new accumulator value comes back per input word. With a non-zero modulus
// the exact 64-bit result is reduced by a shift-subtract remainder unit that
// handles one bit of the 64-bit magnitude per cycle. An item passes through
// accept, compute, sign split, 64 remainder steps and commit; with a zero
// modulus the remainder steps are skipped. The next input word is accepted as
// soon as the previous result is committed, even while that result still
// waits on the output. The modulus register may be written at any time the
// block is idle; its write port is always ready.
module modular_accumulator_alu (
  input  logic           clk,
  input  logic           rst_n,
  maa_in_if.sink         in_ch,
  maa_out_if.source      out_ch,
  maa_cfg_if.sink        cfg_ch
);

  maa_pkg::maa_cmd_t  cmd;
  maa_pkg::maa_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  maa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  maa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_action   (in_ch.action),
    .in_operand  (in_ch.operand),
    .cfg_we      (cfg_ch.valid),
    .cfg_modulus (cfg_ch.modulus),
    .acc         (out_ch.result)
  );

endmodule
